### design/gbn_sw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_sw_pkg
// Shared types and constants for the go-back-n sender window controller.
// ----------------------------------------------------------------------------
package gbn_sw_pkg;

    // field widths
    localparam int CMD_W   = 2;
    localparam int LEN_W   = 23;
    localparam int KIND_W  = 2;
    localparam int IDX_W   = 12;
    localparam int SEQ_W   = 8;
    localparam int PLEN_W  = 11;
    localparam int CNT_W   = 13;
    localparam int TMR_W   = 16;
    localparam int WSZ_W   = 8;
    localparam int WIN_W   = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // transfer limits
    localparam int MAX_PACKETS   = 4096;
    localparam int PAYLOAD_BYTES = 1492;
    localparam int MAX_WINDOW    = 64;
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(MAX_PACKETS * PAYLOAD_BYTES);
    localparam logic [PLEN_W-1:0] FULL_PLEN = PLEN_W'(PAYLOAD_BYTES);
    localparam logic [LEN_W-1:0] PAYLOAD_LEN = LEN_W'(PAYLOAD_BYTES);

    // length split by reciprocal multiply, exact for every length up to LEN_CAP
    localparam int RECIP_W     = 24;
    localparam int RECIP_SHIFT = 34;
    localparam int PROD_W      = LEN_W + RECIP_W;
    localparam logic [RECIP_W-1:0] LEN_RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(PAYLOAD_BYTES) - 64'd1) / 64'(PAYLOAD_BYTES));

    // configuration registers
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = CFG_IDX_W'(1);
    localparam logic [WSZ_W-1:0] WINDOW_RESET  = WSZ_W'(8);
    localparam logic [TMR_W-1:0] TIMEOUT_RESET = TMR_W'(500);

    // command queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef enum logic [CMD_W-1:0] {
        CMD_START = 2'd0,
        CMD_POLL  = 2'd1,
        CMD_ACK   = 2'd2,
        CMD_TICK  = 2'd3
    } t_cmd;

    typedef enum logic [KIND_W-1:0] {
        KIND_NEW  = 2'd0,
        KIND_RETX = 2'd1,
        KIND_DONE = 2'd2
    } t_kind;

    // classified command as it sits in the queue
    typedef struct packed {
        t_cmd              cmd;
        logic [CNT_W-1:0]  total;
        logic [PLEN_W-1:0] last_len;
    } t_qent;

    // valid plus entry on either side of the queue
    typedef struct packed {
        logic  valid;
        t_qent ent;
    } t_qreq;

    // one result item
    typedef struct packed {
        t_kind             kind;
        logic [IDX_W-1:0]  packet_index;
        logic [SEQ_W-1:0]  seq_byte;
        logic              more_follows;
        logic [PLEN_W-1:0] payload_length;
        logic              last_of_run;
    } t_res;

endpackage

### design/gbn_sw_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_sw_in_if
// Command channel: valid/ready handshake with command and file length.
// ----------------------------------------------------------------------------
interface gbn_sw_in_if;
    import gbn_sw_pkg::*;

    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [LEN_W-1:0] file_length;

    modport source (output valid, command, file_length, input ready);
    modport sink (input valid, command, file_length, output ready);
endinterface

### design/gbn_sw_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_sw_out_if
// Result channel: valid/ready handshake with one packet descriptor per item.
// ----------------------------------------------------------------------------
interface gbn_sw_out_if;
    import gbn_sw_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  packet_index;
    logic [SEQ_W-1:0]  seq_byte;
    logic              more_follows;
    logic [PLEN_W-1:0] payload_length;
    logic              last_of_run;

    modport source (output valid, kind, packet_index, seq_byte, more_follows,
                    payload_length, last_of_run, input ready);
    modport sink (input valid, kind, packet_index, seq_byte, more_follows,
                  payload_length, last_of_run, output ready);
endinterface

### design/gbn_sw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_sw_front
// Accepts command items, splits a start length into packet count and last
// packet length with a reciprocal multiply, and pushes classified commands.
// ----------------------------------------------------------------------------
module gbn_sw_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    gbn_sw_in_if.sink           i_in,
    input  logic                i_q_full,
    output gbn_sw_pkg::t_qreq   o_push
);
    import gbn_sw_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_REM,
        ST_PUSH
    } t_state;

    t_state              r_state;
    logic [LEN_W-1:0]    r_len;
    logic [PROD_W-1:0]   r_prod;
    logic [CNT_W-1:0]    r_quo;
    logic [PLEN_W-1:0]   r_rem;
    logic                accept;
    logic                rem_nz;
    logic [LEN_W-1:0]    len_sat;
    logic [CNT_W-1:0]    quo_est;
    logic [LEN_W-1:0]    quo_bytes;
    t_cmd                in_cmd;

    // handshake and decode
    assign in_cmd     = t_cmd'(i_in.command);
    assign i_in.ready = (r_state == ST_IDLE) && !i_q_full;
    assign accept     = i_in.valid && i_in.ready;
    assign len_sat    = (i_in.file_length > LEN_CAP) ? LEN_CAP : i_in.file_length;
    assign rem_nz     = (r_rem != '0);

    // quotient from the product, bytes covered by whole packets
    assign quo_est    = r_prod[RECIP_SHIFT +: CNT_W];
    assign quo_bytes  = LEN_W'(quo_est) * PAYLOAD_LEN;

    // push: other commands go straight in, start after the length split
    always_comb begin
        o_push.valid        = 1'b0;
        o_push.ent.cmd      = in_cmd;
        o_push.ent.total    = '0;
        o_push.ent.last_len = '0;
        if (r_state == ST_PUSH) begin
            o_push.valid        = !i_q_full;
            o_push.ent.cmd      = CMD_START;
            o_push.ent.total    = r_quo + CNT_W'(rem_nz);
            o_push.ent.last_len = rem_nz ? r_rem : FULL_PLEN;
        end else if (accept && in_cmd != CMD_START) begin
            o_push.valid = 1'b1;
        end
    end

    // length split sequencer: multiply, remainder, push
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (accept && in_cmd == CMD_START) begin
                        r_len   <= len_sat;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_prod  <= PROD_W'(r_len) * PROD_W'(LEN_RECIP);
                    r_state <= ST_REM;
                end
                ST_REM: begin
                    r_quo   <= quo_est;
                    r_rem   <= PLEN_W'(r_len - quo_bytes);
                    r_state <= ST_PUSH;
                end
                ST_PUSH: begin
                    if (!i_q_full) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### design/gbn_sw_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_sw_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module gbn_sw_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gbn_sw_pkg::t_qreq   i_push,
    output logic                o_full,
    output gbn_sw_pkg::t_qreq   o_head,
    input  logic                i_pop
);
    import gbn_sw_pkg::*;

    t_qent               r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wptr;
    logic [QPTR_W-1:0]   r_rptr;
    logic [QPTR_W:0]     r_count;
    logic                do_pop;

    assign o_full       = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.ent   = r_mem[r_rptr];
    assign do_pop       = i_pop && o_head.valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wptr] <= i_push.ent;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push.valid) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push.valid, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // never overfilled, never pushed while full
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QPTR_W+1)'(QDEPTH))
        else $error("queue count above depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push.valid)
        else $error("push into full queue");

endmodule

### design/gbn_sw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_sw_back
// Window state machine: carries out queued commands, issues packet
// descriptors, completions and timeout resend runs through an output register.
// ----------------------------------------------------------------------------
module gbn_sw_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [gbn_sw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gbn_sw_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  gbn_sw_pkg::t_qreq                    i_head,
    output logic                                 o_pop,
    gbn_sw_out_if.source                         o_out
);
    import gbn_sw_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state             r_state;
    logic [WSZ_W-1:0]   r_win_size;
    logic [TMR_W-1:0]   r_tmo;
    logic [CNT_W-1:0]   r_base;
    logic [CNT_W-1:0]   r_next;
    logic [CNT_W-1:0]   r_total;
    logic [PLEN_W-1:0]  r_last_len;
    logic [TMR_W-1:0]   r_timer;
    logic               r_active;
    logic [CNT_W-1:0]   r_run_idx;
    logic               r_out_valid;
    t_res               r_out;

    logic               out_free;
    logic [WIN_W-1:0]   win_eff;
    logic [TMR_W-1:0]   tmo_eff;
    logic [TMR_W-1:0]   timer_inc;
    logic               room;
    logic [CNT_W-1:0]   base_ack;
    logic               done_ack;
    logic               run_last;
    logic               emit;

    // build one descriptor
    function automatic t_res f_desc(input t_kind k, input logic [CNT_W-1:0] idx,
                                    input logic [CNT_W-1:0] total,
                                    input logic [PLEN_W-1:0] last_len,
                                    input logic last);
        t_res d;
        logic more;
        more             = ((idx + CNT_W'(1)) != total);
        d.kind           = k;
        d.packet_index   = idx[IDX_W-1:0];
        d.seq_byte       = idx[SEQ_W-1:0];
        d.more_follows   = more;
        d.payload_length = more ? FULL_PLEN : last_len;
        d.last_of_run    = last;
        if (k == KIND_DONE) begin
            d.packet_index   = '0;
            d.seq_byte       = '0;
            d.more_follows   = 1'b0;
            d.payload_length = '0;
        end
        return d;
    endfunction

    // effective settings and window checks
    assign win_eff   = (r_win_size == '0) ? WIN_W'(1) :
                       (r_win_size > WSZ_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) :
                       r_win_size[WIN_W-1:0];
    assign tmo_eff   = (r_tmo == '0) ? TMR_W'(1) : r_tmo;
    assign timer_inc = (r_timer == '1) ? r_timer : r_timer + TMR_W'(1);
    assign room      = ({1'b0, r_next} < ({1'b0, r_base} + (CNT_W+1)'(win_eff)))
                       && (r_next < r_total);
    assign base_ack  = (r_base < r_next) ? r_base + CNT_W'(1) : r_base;
    assign done_ack  = (base_ack == r_next) && (r_next == r_total);
    assign run_last  = ((r_run_idx + CNT_W'(1)) == r_next);

    assign out_free  = !r_out_valid || o_out.ready;
    assign o_pop     = i_head.valid && (r_state == ST_IDLE) && out_free;

    // output port
    assign o_out.valid          = r_out_valid;
    assign o_out.kind           = r_out.kind;
    assign o_out.packet_index   = r_out.packet_index;
    assign o_out.seq_byte       = r_out.seq_byte;
    assign o_out.more_follows   = r_out.more_follows;
    assign o_out.payload_length = r_out.payload_length;
    assign o_out.last_of_run    = r_out.last_of_run;

    // a result item is loaded into the free output slot this cycle
    always_comb begin
        emit = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    case (i_head.ent.cmd)
                        CMD_START: emit = (i_head.ent.total == '0);
                        CMD_POLL:  emit = r_active && room;
                        CMD_ACK:   emit = r_active && done_ack;
                        default:   emit = 1'b0;
                    endcase
                end
            end
            ST_RUN: begin
                emit = out_free;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // state machine, window state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_win_size  <= WINDOW_RESET;
            r_tmo       <= TIMEOUT_RESET;
            r_base      <= '0;
            r_next      <= '0;
            r_total     <= '0;
            r_timer     <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_we && i_cfg_index == CFG_WINDOW) begin
                r_win_size <= i_cfg_data[WSZ_W-1:0];
            end
            if (i_cfg_we && i_cfg_index == CFG_TIMEOUT) begin
                r_tmo <= i_cfg_data[TMR_W-1:0];
            end

            if (out_free) begin
                r_out_valid <= emit;
            end

            case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        case (i_head.ent.cmd)
                            CMD_START: begin
                                r_base     <= '0;
                                r_next     <= '0;
                                r_timer    <= '0;
                                r_total    <= i_head.ent.total;
                                r_last_len <= i_head.ent.last_len;
                                r_active   <= (i_head.ent.total != '0);
                                if (i_head.ent.total == '0) begin
                                    r_out <= f_desc(KIND_DONE, '0, '0, '0, 1'b1);
                                end
                            end
                            CMD_POLL: begin
                                if (r_active && room) begin
                                    r_out <= f_desc(KIND_NEW, r_next, r_total,
                                                    r_last_len, 1'b1);
                                    r_next <= r_next + CNT_W'(1);
                                    if (r_base == r_next) begin
                                        r_timer <= '0;
                                    end
                                end
                            end
                            CMD_ACK: begin
                                if (r_active) begin
                                    r_base  <= base_ack;
                                    r_timer <= '0;
                                    if (done_ack) begin
                                        r_active <= 1'b0;
                                        r_out <= f_desc(KIND_DONE, '0, '0, '0, 1'b1);
                                    end
                                end
                            end
                            CMD_TICK: begin
                                if (r_active) begin
                                    if (timer_inc >= tmo_eff) begin
                                        r_timer <= '0;
                                        if (r_base < r_next) begin
                                            r_run_idx <= r_base;
                                            r_state   <= ST_RUN;
                                        end
                                    end else begin
                                        r_timer <= timer_inc;
                                    end
                                end
                            end
                            default: begin
                                r_timer <= r_timer;
                            end
                        endcase
                    end
                end
                ST_RUN: begin
                    // resend one outstanding packet per free output slot
                    if (out_free) begin
                        r_out <= f_desc(KIND_RETX, r_run_idx, r_total, r_last_len,
                                        run_last);
                        r_run_idx <= r_run_idx + CNT_W'(1);
                        if (run_last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // window ordering
    a_base_le_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_base <= r_next) && (r_next <= r_total))
        else $error("window pointers out of order");
    // a resend run always delivers a retransmission into a free slot
    a_run_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && out_free) |=> (r_out_valid && r_out.kind == KIND_RETX))
        else $error("resend run stalled with free output");
    // completion is only reported once the transfer is closed
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == KIND_DONE) |-> !r_active)
        else $error("completion while transfer active");
    // a run never starts from an empty window
    a_run_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_run_idx < r_next))
        else $error("resend index past next");

endmodule

### design/go_back_n_sender_window_top.sv
`timescale 1ns / 1ps
// A poll, ack or tick result is registered in the command queue and then in the output register.
// Polls, acks and ticks are taken one item per cycle while the queue is not full; a start
// holds the front through accept, reciprocal multiply, remainder and queue push.
// A timeout resend emits a descriptor per outstanding packet, up to 64, one per unstalled cycle.
// Reset: synchronous active low; window 8, timeout 500, idle, queue empty.
// ----------------------------------------------------------------------------
// go_back_n_sender_window_top
// Go-back-n sender window controller: front classifier, command queue and
// window state machine with a registered result output.
// ----------------------------------------------------------------------------
module go_back_n_sender_window_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [gbn_sw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gbn_sw_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    gbn_sw_in_if.sink                            i_in,
    gbn_sw_out_if.source                         o_out
);
    import gbn_sw_pkg::*;

    t_qreq  push;
    t_qreq  head;
    logic   q_full;
    logic   pop;

    // command classification and length split
    gbn_sw_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push)
    );

    // decoupling queue
    gbn_sw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .o_head  (head),
        .i_pop   (pop)
    );

    // window state machine
    gbn_sw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_head      (head),
        .o_pop       (pop),
        .o_out       (o_out)
    );

endmodule

### sim/gbn_sw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_sw_checker
// Watches the register port and both channels of the go-back-n sender window.
// Keeps its own copy of the window state and registers, works out the packet
// descriptors that each accepted command item causes, and compares every
// result item with the oldest outstanding descriptor, field by field.
// ----------------------------------------------------------------------------
module gbn_sw_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [gbn_sw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gbn_sw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    gbn_sw_in_if                              i_cmd,
    gbn_sw_out_if                             i_res,
    output int                                o_fail_count,
    output int                                o_pending
);
    import gbn_sw_pkg::*;

    localparam int TMR_MAX    = (1 << TMR_W) - 1;
    localparam int REPORT_MAX = 10;

    // register copies
    logic [WSZ_W-1:0] window_reg;
    logic [TMR_W-1:0] timeout_reg;

    // window state
    int unsigned base_idx;
    int unsigned next_idx;
    int unsigned pkt_total;
    int unsigned byte_cnt;
    int unsigned tick_cnt;
    bit          sending;

    // descriptors still owed by the block, oldest first
    t_res desc_q[$];

    // build one descriptor from the current transfer
    function automatic t_res make_desc(input t_kind kind, input int unsigned idx,
                                       input bit last);
        t_res        d;
        int unsigned first_byte;
        int unsigned remain;
        d = '0;
        d.kind = kind;
        if (kind != KIND_DONE) begin
            first_byte = idx * PAYLOAD_BYTES;
            remain = (first_byte < byte_cnt) ? byte_cnt - first_byte : 0;
            d.packet_index   = IDX_W'(idx);
            d.seq_byte       = SEQ_W'(idx);
            d.more_follows   = (idx + 1 != pkt_total);
            d.payload_length = PLEN_W'((remain < PAYLOAD_BYTES) ? remain : PAYLOAD_BYTES);
        end
        d.last_of_run = last;
        return d;
    endfunction

    // advance the window by one command item and queue what it emits
    task automatic predict_descriptors(input t_cmd cmd, input logic [LEN_W-1:0] flen);
        int unsigned win;
        int unsigned tmo;
        int unsigned len;
        int unsigned i;
        int          n;
        win = (window_reg == 0) ? 1 : window_reg;
        if (win > MAX_WINDOW) win = MAX_WINDOW;
        tmo = (timeout_reg == 0) ? 1 : timeout_reg;
        n = 0;
        case (cmd)
            CMD_START: begin
                len = (flen > LEN_CAP) ? LEN_CAP : flen;
                byte_cnt  = len;
                pkt_total = (len + PAYLOAD_BYTES - 1) / PAYLOAD_BYTES;
                base_idx  = 0;
                next_idx  = 0;
                tick_cnt  = 0;
                sending   = (pkt_total != 0);
                // empty transfer completes on the spot
                if (!sending) desc_q.push_back(make_desc(KIND_DONE, 0, 1'b1));
            end
            CMD_POLL: begin
                if (sending && next_idx < base_idx + win && next_idx < pkt_total) begin
                    desc_q.push_back(make_desc(KIND_NEW, next_idx, 1'b1));
                    if (base_idx == next_idx) tick_cnt = 0;
                    next_idx++;
                end
            end
            CMD_ACK: begin
                if (sending) begin
                    // never move the base past what was sent
                    if (base_idx < next_idx) base_idx++;
                    tick_cnt = 0;
                    if (base_idx == next_idx && next_idx == pkt_total) begin
                        sending = 1'b0;
                        desc_q.push_back(make_desc(KIND_DONE, 0, 1'b1));
                    end
                end
            end
            CMD_TICK: begin
                if (sending) begin
                    if (tick_cnt < TMR_MAX) tick_cnt++;
                    // timeout: resend everything outstanding as one run
                    if (tick_cnt >= tmo) begin
                        tick_cnt = 0;
                        for (i = base_idx; i < next_idx && n < MAX_WINDOW; i++) begin
                            desc_q.push_back(make_desc(KIND_RETX, i,
                                (i + 1 == next_idx) || (n + 1 == MAX_WINDOW)));
                            n++;
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    function automatic string show(input t_res d);
        return $sformatf("kind %0d idx %0d seq %0d more %0b len %0d last %0b",
                         d.kind, d.packet_index, d.seq_byte, d.more_follows,
                         d.payload_length, d.last_of_run);
    endfunction

    // sample the ports at each edge: registers, then commands, then results
    always @(posedge i_clk) begin : watch
        t_res got;
        t_res want;
        if (!i_rst_n) begin
            window_reg   = WINDOW_RESET;
            timeout_reg  = TIMEOUT_RESET;
            base_idx     = 0;
            next_idx     = 0;
            pkt_total    = 0;
            byte_cnt     = 0;
            tick_cnt     = 0;
            sending      = 1'b0;
            o_fail_count = 0;
            desc_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WINDOW:  window_reg = i_cfg_data[WSZ_W-1:0];
                    CFG_TIMEOUT: timeout_reg = i_cfg_data[TMR_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.valid && i_cmd.ready) begin
                predict_descriptors(t_cmd'(i_cmd.command), i_cmd.file_length);
            end
            if (i_res.valid && i_res.ready) begin
                got.kind           = t_kind'(i_res.kind);
                got.packet_index   = i_res.packet_index;
                got.seq_byte       = i_res.seq_byte;
                got.more_follows   = i_res.more_follows;
                got.payload_length = i_res.payload_length;
                got.last_of_run    = i_res.last_of_run;
                if (desc_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_MAX)
                        $display("%0t: unexpected result item: %s", $time, show(got));
                end else begin
                    want = desc_q.pop_front();
                    if (got.kind !== want.kind || got.packet_index !== want.packet_index ||
                        got.seq_byte !== want.seq_byte ||
                        got.more_follows !== want.more_follows ||
                        got.payload_length !== want.payload_length ||
                        got.last_of_run !== want.last_of_run) begin
                        o_fail_count++;
                        if (o_fail_count <= REPORT_MAX)
                            $display("%0t: mismatch, expected %s, actual %s",
                                     $time, show(want), show(got));
                    end
                end
            end
        end
        o_pending = desc_q.size();
    end

endmodule

### sim/tb_go_back_n_sender_window_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_go_back_n_sender_window_top
// Drives command items into the go-back-n sender window under several window
// and timeout settings: a directed opening on idle commands, empty, oversized
// and abandoned transfers, full windows and resends, then orderly and shuffled
// transfers with random lengths, including one full 64-packet resend run.
// Both channels idle at random; the checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module tb_go_back_n_sender_window_top;
    import gbn_sw_pkg::*;

    localparam int SETTLE_CYCLES = 80;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int RUN_LIMIT_NS  = 4_000_000;
    localparam int MODE_SWAP     = 50;
    localparam int MODE_QUIET    = 100;
    localparam int TICK_CAP      = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending_count;
    int                    send_idle_pct;
    int                    recv_idle_pct;
    int                    accepted;
    int                    win_eff;
    int                    tmo_eff;

    gbn_sw_in_if  cmd_ch ();
    gbn_sw_out_if res_ch ();

    go_back_n_sender_window_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (cmd_ch),
        .o_out       (res_ch)
    );

    gbn_sw_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_cmd        (cmd_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // 4 ns clock
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // result side stalls at random
    always @(posedge clk) begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // one command item, with random idle cycles ahead of it
    task automatic send_item(input t_cmd cmd, input logic [LEN_W-1:0] len);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.command     <= cmd;
        cmd_ch.file_length <= (cmd == CMD_START) ? len : LEN_W'($urandom);
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
        accepted++;
        if (accepted == MODE_SWAP) begin
            send_idle_pct = 76;
            recv_idle_pct = 21;
        end else if (accepted == MODE_QUIET) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    // wait until every descriptor is out and the block has drained
    task automatic settle();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // new window and timeout, plus a write to an unused index
    task automatic set_config(input logic [CFG_DATA_W-1:0] win_data,
                              input logic [CFG_DATA_W-1:0] tmo_data);
        logic [WSZ_W-1:0] w;
        settle();
        write_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, CFG_DATA_W'($urandom));
        write_reg(CFG_WINDOW, win_data);
        write_reg(CFG_TIMEOUT, tmo_data);
        cfg_we <= 1'b0;
        w = win_data[WSZ_W-1:0];
        win_eff = (w == 0) ? 1 : (w > MAX_WINDOW) ? MAX_WINDOW : w;
        tmo_eff = (tmo_data == 0) ? 1 : tmo_data;
    endtask

    // fill the window, tick at most TICK_CAP times toward a timeout, ack it all; repeat until done
    task automatic orderly_transfer(input int npk);
        int sent;
        int chunk;
        send_item(CMD_START,
                  LEN_W'(npk * PAYLOAD_BYTES - $urandom_range(0, PAYLOAD_BYTES - 1)));
        sent = 0;
        while (sent < npk) begin
            chunk = (npk - sent < win_eff) ? npk - sent : win_eff;
            // one poll beyond the chunk finds the window full or every packet sent
            repeat (chunk + 1) send_item(CMD_POLL, '0);
            repeat ((tmo_eff < TICK_CAP) ? tmo_eff : TICK_CAP) send_item(CMD_TICK, '0);
            repeat (chunk) send_item(CMD_ACK, '0);
            sent += chunk;
        end
    endtask

    // random length, then a shuffled mix of polls, acks and ticks
    task automatic mixed_transfer();
        int               pick;
        int               steps;
        logic [LEN_W-1:0] len;
        pick = $urandom_range(99);
        if (pick < 8) len = '0;
        else if (pick < 15) len = LEN_W'($urandom);
        else if (pick < 35) len = LEN_W'($urandom_range(1, 6) * PAYLOAD_BYTES);
        else len = LEN_W'($urandom_range(1, 6 * PAYLOAD_BYTES));
        send_item(CMD_START, len);
        steps = (len > 8 * PAYLOAD_BYTES) ? 35
                : 4 * ((len + PAYLOAD_BYTES - 1) / PAYLOAD_BYTES) + 3;
        repeat (steps) begin
            pick = $urandom_range(99);
            if (pick < 42) send_item(CMD_POLL, '0);
            else if (pick < 76) send_item(CMD_ACK, '0);
            else if (pick < 97) send_item(CMD_TICK, '0);
            else send_item(CMD_START, LEN_W'($urandom_range(0, 3 * PAYLOAD_BYTES)));
        end
    endtask

    task automatic random_phase(input logic [CFG_DATA_W-1:0] win_data,
                                input logic [CFG_DATA_W-1:0] tmo_data);
        set_config(win_data, tmo_data);
        if ($urandom_range(1)) orderly_transfer($urandom_range(1, 4));
        else mixed_transfer();
    endtask

    // stimulus
    initial begin
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= CFG_WINDOW;
        cfg_data           <= '0;
        cmd_ch.valid       <= 1'b0;
        cmd_ch.command     <= CMD_POLL;
        cmd_ch.file_length <= '0;
        send_idle_pct = 21;
        recv_idle_pct = 76;
        accepted      = 0;
        win_eff       = WINDOW_RESET;
        tmo_eff       = TIMEOUT_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle block ignores everything but a start
        send_item(CMD_POLL, '0);
        send_item(CMD_ACK, '0);
        send_item(CMD_TICK, '0);
        // empty transfer
        send_item(CMD_START, '0);
        // oversized length saturates, then a start abandons it
        send_item(CMD_START, '1);
        send_item(CMD_POLL, '0);
        send_item(CMD_START, LEN_W'(2 * PAYLOAD_BYTES + 1));
        // ack with nothing outstanding
        send_item(CMD_ACK, '0);
        // three packets, short last one, then a poll with all sent
        repeat (4) send_item(CMD_POLL, '0);
        repeat (3) send_item(CMD_ACK, '0);

        // window register 0 acts as 1, timeout 0 fires on every tick
        set_config(16'hFF00, 16'd0);
        send_item(CMD_START, LEN_W'(3 * PAYLOAD_BYTES));
        repeat (2) send_item(CMD_POLL, '0);
        send_item(CMD_TICK, '0);
        send_item(CMD_ACK, '0);
        // timeout with nothing outstanding
        send_item(CMD_TICK, '0);
        send_item(CMD_POLL, '0);

        // random part over several settings
        random_phase(16'd1, 16'd1);
        random_phase(16'd4, 16'd3);
        // widest window: fill 64 packets and time out for a full resend run
        set_config(16'd128, 16'd2);
        send_item(CMD_START, LEN_W'(MAX_WINDOW * PAYLOAD_BYTES));
        repeat (MAX_WINDOW) send_item(CMD_POLL, '0);
        repeat (2) send_item(CMD_TICK, '0);
        random_phase(16'hFF08, 16'd5);
        random_phase(CFG_DATA_W'($urandom_range(1, 128)), CFG_DATA_W'($urandom_range(1, 6)));
        random_phase(16'd255, 16'hFFFF);
        random_phase(16'd2, 16'd4);

        // drain and report
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        for (int c = 0; c < DRAIN_LIMIT && pending_count != 0; c++) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("tb_go_back_n_sender_window_top OK");
        end else begin
            $display("tb_go_back_n_sender_window_top NOT OK");
        end
        $finish;
    end

    // hang guard
    initial begin
        #(RUN_LIMIT_NS);
        $display("tb_go_back_n_sender_window_top NOT OK");
        $finish;
    end

endmodule
